[hdl/u8u16_pkg.sv]
// types and constants shared by the utf-8 to utf-16 decoder
// no dependencies; compile first
package u8u16_pkg;

	localparam logic [7:0] BYTE_CONT_MASK = 8'hc0;
	localparam logic [7:0] BYTE_CONT_TAG  = 8'h80;
	localparam logic [7:0] BYTE_LOW6_MASK = 8'h3f;
	localparam logic [7:0] LEAD_TWO_MIN   = 8'hc0;
	localparam logic [7:0] LEAD_THREE_MIN = 8'he0;
	localparam logic [7:0] LEAD_FOUR_MIN  = 8'hf0;
	localparam logic [7:0] LEAD_FIVE_MIN  = 8'hf8;
	localparam logic [7:0] LEAD_SIX_MIN   = 8'hfc;
	localparam logic [15:0] COUNT_MAX     = 16'hffff;

	typedef enum logic [1:0] {
		KIND_NONE  = 2'd0,
		KIND_TWO   = 2'd1,
		KIND_THREE = 2'd2
	} seq_kind_t;

	typedef struct packed {
		logic [2:0]  bytes_pending;
		seq_kind_t   sequence_kind;
		logic [7:0]  lead_held;
		logic [7:0]  first_cont_held;
		logic [15:0] unit_counter;
	} dec_state_t;

	typedef struct packed {
		logic        unit_valid;
		logic [15:0] code_unit;
		logic [15:0] units_so_far;
		logic        string_done;
	} dec_result_t;

	function automatic logic is_cont(input logic [7:0] b);
		return (b & BYTE_CONT_MASK) == BYTE_CONT_TAG;
	endfunction

endpackage

[hdl/u8u16_channels.sv]
// handshake channels of the utf-8 to utf-16 decoder
// no dependencies beyond plain logic types
interface u8u16_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] data_byte;
	logic       last_byte;

	modport source (output valid, output data_byte, output last_byte, input ready);
	modport sink (input valid, input data_byte, input last_byte, output ready);
endinterface

interface u8u16_out_if;
	logic        valid;
	logic        ready;
	logic        unit_valid;
	logic [15:0] code_unit;
	logic [15:0] units_so_far;
	logic        string_done;

	modport source (output valid, output unit_valid, output code_unit,
		output units_so_far, output string_done, input ready);
	modport sink (input valid, input unit_valid, input code_unit,
		input units_so_far, input string_done, output ready);
endinterface

[hdl/utf8_to_utf16_decoder.sv]
// utf-8 to utf-16 decoder top level, basic multilingual plane only
// depends on u8u16_pkg, u8u16_channels and u8u16_step
//
//  channel   dir  payload                                          per item
//  in_ch     in   data_byte[7:0], last_byte                        one byte
//  out_ch    out  unit_valid, code_unit[15:0], units_so_far[15:0],  one result
//                 string_done
//
// one result per byte, shown in the cycle after the byte is taken; one byte per cycle
// while out_ch does not stall, set by the single result register after the decode step
// in_ch.ready is high while the result register is empty or being drained
// a stall on out_ch holds the result and stops intake for as long as it lasts
// arst_n clears the sequence state, the unit count and the result valid
module utf8_to_utf16_decoder
	import u8u16_pkg::*;
(
	input logic        clk,
	input logic        arst_n,
	u8u16_in_if.sink   in_ch,
	u8u16_out_if.source out_ch
);

	dec_state_t  state_q;
	dec_state_t  state_nxt;
	dec_result_t res_nxt;
	dec_result_t res_s1;
	logic        valid_s1;
	logic        take;

	assign in_ch.ready = !valid_s1 || out_ch.ready;
	assign take        = in_ch.valid && in_ch.ready;

	u8u16_step step_u (
		.cur       (state_q),
		.data_byte (in_ch.data_byte),
		.last_byte (in_ch.last_byte),
		.nxt       (state_nxt),
		.res       (res_nxt)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q  <= '0;
			valid_s1 <= 1'b0;
		end else begin
			if (take)
				state_q <= state_nxt;
			if (take)
				valid_s1 <= 1'b1;
			else if (out_ch.ready)
				valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take)
			res_s1 <= res_nxt;
	end

	assign out_ch.valid        = valid_s1;
	assign out_ch.unit_valid   = res_s1.unit_valid;
	assign out_ch.code_unit    = res_s1.code_unit;
	assign out_ch.units_so_far = res_s1.units_so_far;
	assign out_ch.string_done  = res_s1.string_done;

endmodule

[hdl/u8u16_step.sv]
// per-byte decode step: next sequence state and the result for one byte
// depends on u8u16_pkg
module u8u16_step
	import u8u16_pkg::*;
(
	input  dec_state_t  cur,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output dec_state_t  nxt,
	output dec_result_t res
);

	logic [2:0]  pend_dec;
	logic        valid;
	logic [15:0] unit;
	logic [15:0] count_new;

	assign pend_dec = cur.bytes_pending - 3'd1;

	always_comb begin
		nxt   = cur;
		valid = 1'b0;
		unit  = '0;
		if (cur.bytes_pending != 3'd0) begin
			nxt.bytes_pending = pend_dec;
			unique case (cur.sequence_kind)
				KIND_TWO: begin
					if (pend_dec == 3'd0 && is_cont(data_byte)) begin
						valid = 1'b1;
						unit  = {5'd0, cur.lead_held[4:0], data_byte[5:0]};
					end
				end
				KIND_THREE: begin
					if (pend_dec == 3'd1) begin
						nxt.first_cont_held = data_byte;
					end else if (pend_dec == 3'd0 && is_cont(cur.first_cont_held)
						&& is_cont(data_byte)) begin
						valid = 1'b1;
						unit  = {cur.lead_held[3:0], cur.first_cont_held[5:0],
							data_byte[5:0]};
					end
				end
				default: begin
					// skipped sequence: bytes consumed, nothing emitted
				end
			endcase
			if (pend_dec == 3'd0)
				nxt.sequence_kind = KIND_NONE;
		end else begin
			priority if (data_byte < BYTE_CONT_TAG) begin
				valid = 1'b1;
				unit  = {8'd0, data_byte};
			end else if (data_byte < LEAD_TWO_MIN) begin
				// stray continuation is dropped
			end else if (data_byte < LEAD_THREE_MIN) begin
				nxt.sequence_kind = KIND_TWO;
				nxt.bytes_pending = 3'd1;
				nxt.lead_held     = data_byte;
			end else if (data_byte < LEAD_FOUR_MIN) begin
				nxt.sequence_kind = KIND_THREE;
				nxt.bytes_pending = 3'd2;
				nxt.lead_held     = data_byte;
			end else if (data_byte < LEAD_FIVE_MIN) begin
				nxt.sequence_kind = KIND_NONE;
				nxt.bytes_pending = 3'd3;
				nxt.lead_held     = data_byte;
			end else if (data_byte < LEAD_SIX_MIN) begin
				nxt.sequence_kind = KIND_NONE;
				nxt.bytes_pending = 3'd4;
				nxt.lead_held     = data_byte;
			end else begin
				nxt.sequence_kind = KIND_NONE;
				nxt.bytes_pending = 3'd5;
				nxt.lead_held     = data_byte;
			end
		end

		count_new = cur.unit_counter;
		if (valid && cur.unit_counter != COUNT_MAX)
			count_new = cur.unit_counter + 16'd1;
		nxt.unit_counter = count_new;

		res.unit_valid   = valid;
		res.code_unit    = unit;
		res.units_so_far = count_new;
		res.string_done  = last_byte;

		// final byte closes the string and drops any open sequence
		if (last_byte)
			nxt = '0;
	end

endmodule

[hdl/u8u16_checker.sv]
// port-level checks for the utf-8 to utf-16 decoder, bound to the top level
// depends on utf8_to_utf16_decoder and the channel interfaces
module u8u16_checker (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_ready,
	input logic        out_valid,
	input logic        out_ready,
	input logic        unit_valid,
	input logic [15:0] code_unit,
	input logic [15:0] units_so_far
);

	// a taken byte always shows a result on the next cycle
	a_result_follows: assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && in_ready |=> out_valid)
		else $error("no result after a taken item");

	// intake never stalls with an empty result register
	a_ready_when_empty: assert property (@(posedge clk) disable iff (!arst_n)
		!out_valid |-> in_ready)
		else $error("input stalled with empty result register");

	// no unit means a zero code unit
	a_zero_unit: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !unit_valid |-> code_unit == 16'd0)
		else $error("code unit nonzero without a unit");

	// an emitted unit is counted
	a_count_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && unit_valid |-> units_so_far != 16'd0)
		else $error("unit emitted with zero count");

	// stalled result holds
	a_stall_hold: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && !out_ready |=> out_valid && $stable(code_unit)
			&& $stable(units_so_far))
		else $error("stalled result changed");

endmodule

bind utf8_to_utf16_decoder u8u16_checker chk_u (
	.clk          (clk),
	.arst_n       (arst_n),
	.in_valid     (in_ch.valid),
	.in_ready     (in_ch.ready),
	.out_valid    (out_ch.valid),
	.out_ready    (out_ch.ready),
	.unit_valid   (out_ch.unit_valid),
	.code_unit    (out_ch.code_unit),
	.units_so_far (out_ch.units_so_far)
);

[dv/utf8_to_utf16_decoder_test.sv]
`timescale 1ns / 1ps
// self-checking bench for utf8_to_utf16_decoder: a directed byte table and random strings
// depends on u8u16_pkg, u8u16_channels and the decoder rtl
module utf8_to_utf16_decoder_test;
	import u8u16_pkg::*;

	localparam int HALF_PERIOD  = 4;
	localparam int RESET_CYCLES = 7;
	localparam int CYCLE_LIMIT  = 40000;
	localparam int DRAIN_CYCLES = 4;
	localparam int PHASE_ITEMS  = 620;
	localparam int LONG_HOLD    = 150;
	localparam int PROBE_COUNT  = 28;
	localparam int PRINT_CAP    = 100;

	typedef struct packed {
		logic [7:0]  data_byte;
		logic        last_byte;
		logic        pinned;
		dec_result_t want;
	} probe_row_t;

	// rows with pinned set carry their result; the rest go through the predictor
	probe_row_t probe_rows [PROBE_COUNT] = '{
		'{8'h00, 1'b0, 1'b1, '{1'b1, 16'h0000, 16'd1, 1'b0}},
		'{8'h7f, 1'b0, 1'b1, '{1'b1, 16'h007f, 16'd2, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd2, 1'b0}},
		'{8'hbf, 1'b1, 1'b1, '{1'b0, 16'h0000, 16'd2, 1'b1}},
		'{8'hc2, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd0, 1'b0}},
		'{8'ha9, 1'b0, 1'b1, '{1'b1, 16'h00a9, 16'd1, 1'b0}},
		'{8'hc0, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd1, 1'b0}},
		'{8'h80, 1'b0, 1'b1, '{1'b1, 16'h0000, 16'd2, 1'b0}},
		'{8'hdf, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd2, 1'b0}},
		'{8'hbf, 1'b0, 1'b1, '{1'b1, 16'h07ff, 16'd3, 1'b0}},
		'{8'hef, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd3, 1'b0}},
		'{8'hbf, 1'b0, 1'b1, '{1'b0, 16'h0000, 16'd3, 1'b0}},
		'{8'hbf, 1'b0, 1'b1, '{1'b1, 16'hffff, 16'd4, 1'b0}},
		// lead byte swallowed as the first continuation
		'{8'he0, 1'b0, 1'b0, '0},
		'{8'hc3, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// four-byte lead skips any three bytes
		'{8'hf0, 1'b0, 1'b0, '0},
		'{8'hff, 1'b0, 1'b0, '0},
		'{8'h00, 1'b0, 1'b0, '0},
		'{8'h80, 1'b0, 1'b0, '0},
		// three-byte sequence cut off by the last byte
		'{8'he4, 1'b0, 1'b0, '0},
		'{8'hb8, 1'b1, 1'b1, '{1'b0, 16'h0000, 16'd4, 1'b1}},
		// six-byte skip ending exactly on the last byte
		'{8'hfc, 1'b0, 1'b0, '0},
		'{8'hbf, 1'b0, 1'b0, '0},
		'{8'hc2, 1'b0, 1'b0, '0},
		'{8'he0, 1'b0, 1'b0, '0},
		'{8'hf8, 1'b0, 1'b0, '0},
		'{8'h7f, 1'b1, 1'b0, '0}
	};

	logic clk = 1'b0;
	logic arst_n;

	u8u16_in_if  byte_ch ();
	u8u16_out_if unit_ch ();

	utf8_to_utf16_decoder i_dut (
		.clk    (clk),
		.arst_n (arst_n),
		.in_ch  (byte_ch),
		.out_ch (unit_ch)
	);

	always #(HALF_PERIOD) clk = ~clk;

	int          send_idle_pct;
	int          recv_idle_pct;
	bit          long_hold_req;
	int          error_count;
	int          cycle_count;
	logic        pin_on;
	dec_result_t pin_want;
	dec_result_t expected_units [$];

	// decoder state as the bench sees it
	logic [2:0]  pend_bytes   = '0;
	seq_kind_t   open_kind    = KIND_NONE;
	logic [7:0]  held_lead    = '0;
	logic [7:0]  held_cont    = '0;
	logic [15:0] string_units = '0;

	function automatic dec_result_t decode_byte(input logic [7:0] b, input logic fin);
		dec_result_t r;
		r = '0;
		if (pend_bytes != 0) begin
			pend_bytes = pend_bytes - 3'd1;
			if (open_kind == KIND_TWO) begin
				if (pend_bytes == 0 && b[7:6] == 2'b10) begin
					r.unit_valid = 1'b1;
					r.code_unit  = {5'd0, held_lead[4:0], b[5:0]};
				end
			end else if (open_kind == KIND_THREE) begin
				if (pend_bytes == 1) begin
					held_cont = b;
				end else if (pend_bytes == 0 && held_cont[7:6] == 2'b10 && b[7:6] == 2'b10) begin
					r.unit_valid = 1'b1;
					r.code_unit  = {held_lead[3:0], held_cont[5:0], b[5:0]};
				end
			end
			if (pend_bytes == 0)
				open_kind = KIND_NONE;
		end else if (b < BYTE_CONT_TAG) begin
			r.unit_valid = 1'b1;
			r.code_unit  = {8'd0, b};
		end else if (b < LEAD_TWO_MIN) begin
			// stray continuation, nothing to do
		end else if (b < LEAD_THREE_MIN) begin
			open_kind  = KIND_TWO;
			pend_bytes = 3'd1;
			held_lead  = b;
		end else if (b < LEAD_FOUR_MIN) begin
			open_kind  = KIND_THREE;
			pend_bytes = 3'd2;
			held_lead  = b;
		end else begin
			open_kind  = KIND_NONE;
			pend_bytes = (b < LEAD_FIVE_MIN) ? 3'd3 : (b < LEAD_SIX_MIN) ? 3'd4 : 3'd5;
			held_lead  = b;
		end
		if (r.unit_valid && string_units != COUNT_MAX)
			string_units = string_units + 16'd1;
		r.units_so_far = string_units;
		r.string_done  = fin;
		if (fin) begin
			pend_bytes   = '0;
			open_kind    = KIND_NONE;
			held_lead    = '0;
			held_cont    = '0;
			string_units = '0;
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [15:0] got,
		input logic [15:0] want);
		error_count++;
		if (error_count <= PRINT_CAP)
			$display("mismatch at %0t ns: %s got %h want %h", $time, what, got, want);
	endtask

	always @(posedge clk) begin : watch
		dec_result_t want;
		if (arst_n) begin
			if (unit_ch.valid && unit_ch.ready) begin
				if (expected_units.size() == 0) begin
					report_mismatch("unit with no item pending", unit_ch.code_unit, '0);
				end else begin
					want = expected_units.pop_front();
					if (unit_ch.unit_valid !== want.unit_valid)
						report_mismatch("unit_valid", 16'(unit_ch.unit_valid), 16'(want.unit_valid));
					if (unit_ch.code_unit !== want.code_unit)
						report_mismatch("code_unit", unit_ch.code_unit, want.code_unit);
					if (unit_ch.units_so_far !== want.units_so_far)
						report_mismatch("units_so_far", unit_ch.units_so_far, want.units_so_far);
					if (unit_ch.string_done !== want.string_done)
						report_mismatch("string_done", 16'(unit_ch.string_done),
							16'(want.string_done));
				end
			end
			if (byte_ch.valid && byte_ch.ready) begin
				want = decode_byte(byte_ch.data_byte, byte_ch.last_byte);
				expected_units.push_back(pin_on ? pin_want : want);
			end
		end
	end

	// receiver, with one long hold-off so the decoder backs up into its input
	initial begin
		int hold_left;
		bit hold_used;
		hold_left = 0;
		hold_used = 1'b0;
		unit_ch.ready = 1'b0;
		forever begin
			@(negedge clk);
			if (long_hold_req && !hold_used) begin
				hold_left = LONG_HOLD;
				hold_used = 1'b1;
			end
			if (hold_left > 0) begin
				unit_ch.ready <= 1'b0;
				hold_left--;
			end else begin
				unit_ch.ready <= ($urandom_range(99) >= recv_idle_pct);
			end
		end
	end

	initial begin
		for (cycle_count = 0; cycle_count < CYCLE_LIMIT; cycle_count++)
			@(posedge clk);
		$display("timeout after %0d cycles", cycle_count);
		$display("FAILURE");
		$finish;
	end

	task automatic offer_byte(input logic [7:0] b, input logic fin, input logic pinned,
		input dec_result_t want);
		@(negedge clk);
		while ($urandom_range(99) < send_idle_pct) begin
			byte_ch.valid <= 1'b0;
			@(negedge clk);
		end
		byte_ch.valid     <= 1'b1;
		byte_ch.data_byte <= b;
		byte_ch.last_byte <= fin;
		pin_on            <= pinned;
		pin_want          <= want;
		do
			@(posedge clk);
		while (!byte_ch.ready);
	endtask

	task automatic pause_until_drained();
		@(negedge clk);
		byte_ch.valid <= 1'b0;
		while (expected_units.size() != 0)
			@(posedge clk);
	endtask

	function automatic logic [7:0] cont_byte();
		return BYTE_CONT_TAG | 8'($urandom_range(63));
	endfunction

	// strings built mostly of well-formed sequences, with skips, broken sequences and noise
	task automatic send_random_strings(input int item_goal);
		logic [7:0] text [$];
		int sent;
		int pieces;
		int pick;
		int span;
		sent = 0;
		while (sent < item_goal) begin
			text.delete();
			pieces = $urandom_range(1, 12);
			repeat (pieces) begin
				pick = $urandom_range(99);
				if (pick < 30) begin
					text.push_back(8'($urandom_range(127)));
				end else if (pick < 50) begin
					text.push_back(LEAD_TWO_MIN | 8'($urandom_range(31)));
					text.push_back(cont_byte());
				end else if (pick < 70) begin
					text.push_back(LEAD_THREE_MIN | 8'($urandom_range(15)));
					text.push_back(cont_byte());
					text.push_back(cont_byte());
				end else if (pick < 78) begin
					span = $urandom_range(4, 6);
					case (span)
						4: text.push_back(LEAD_FOUR_MIN | 8'($urandom_range(7)));
						5: text.push_back(LEAD_FIVE_MIN | 8'($urandom_range(3)));
						default: text.push_back(LEAD_SIX_MIN | 8'($urandom_range(3)));
					endcase
					repeat (span - 1)
						text.push_back(8'($urandom));
				end else if (pick < 90) begin
					// lead followed by an arbitrary byte where a continuation belongs
					if ($urandom_range(1)) begin
						text.push_back(LEAD_TWO_MIN | 8'($urandom_range(31)));
						text.push_back(8'($urandom));
					end else begin
						text.push_back(LEAD_THREE_MIN | 8'($urandom_range(15)));
						if ($urandom_range(1)) begin
							text.push_back(cont_byte());
							text.push_back(8'($urandom));
						end else begin
							text.push_back(8'($urandom));
							text.push_back(cont_byte());
						end
					end
				end else begin
					text.push_back(8'($urandom));
				end
			end
			if ($urandom_range(99) < 15 && text.size() > 1)
				void'(text.pop_back());
			foreach (text[i])
				offer_byte(text[i], i == text.size() - 1, 1'b0, '0);
			sent += text.size();
		end
	endtask

	initial begin
		int row;
		arst_n            = 1'b0;
		byte_ch.valid     = 1'b0;
		byte_ch.data_byte = '0;
		byte_ch.last_byte = 1'b0;
		pin_on            = 1'b0;
		pin_want          = '0;
		long_hold_req     = 1'b0;
		error_count       = 0;
		send_idle_pct     = 28;
		recv_idle_pct     = 59;
		repeat (RESET_CYCLES)
			@(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		for (row = 0; row < PROBE_COUNT; row++)
			offer_byte(probe_rows[row].data_byte, probe_rows[row].last_byte,
				probe_rows[row].pinned, probe_rows[row].want);
		pause_until_drained();

		long_hold_req = 1'b1;
		send_random_strings(PHASE_ITEMS);
		pause_until_drained();

		send_idle_pct = 59;
		recv_idle_pct = 28;
		send_random_strings(PHASE_ITEMS);
		pause_until_drained();

		send_idle_pct = 0;
		recv_idle_pct = 0;
		send_random_strings(PHASE_ITEMS);
		pause_until_drained();

		repeat (DRAIN_CYCLES)
			@(posedge clk);
		if (error_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

[utf8_to_utf16_decoder.f]
hdl/u8u16_pkg.sv
hdl/u8u16_channels.sv
hdl/u8u16_step.sv
hdl/utf8_to_utf16_decoder.sv
hdl/u8u16_checker.sv
dv/utf8_to_utf16_decoder_test.sv
